// File: hdl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared constants, types and the CRC-8 step function of the tag frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0] HIGH_MASK     = 8'h1F;
    localparam logic [7:0] CRC_POLY      = 8'h31;
    localparam logic [7:0] CRC_INIT      = 8'hFF;
    localparam logic [7:0] CRC_TOP       = 8'h80;

    localparam int ID_W   = 16;

    // Result of one parser step: a found frame and its ID.
    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
    } t_tfp_result;

    // One byte through the CRC-8 register, most significant bit first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/tfp_parser.sv
// ----------------------------------------------------------------------------
// tfp_parser
// Frame state machine: preamble hunt, ID capture, CRC-8 and XOR checks.
// ----------------------------------------------------------------------------
module tfp_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    output tfp_pkg::t_tfp_result      o_result
);
    import tfp_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT = 3'd0,
        S_PRE2 = 3'd1,
        S_SKIP = 3'd2,
        S_LOW  = 3'd3,
        S_CRC  = 3'd4,
        S_XOR  = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_id, n_id;

    // The CRC is carried one byte at a time: after the high byte the register
    // holds the partial CRC, after the low byte the full value.
    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_crc       = r_crc;
        n_id        = r_id;
        o_result.hit = 1'b0;
        o_result.id  = r_id;
        unique case (r_phase)
            S_HUNT: begin
                if (i_byte == PREAMBLE_BYTE) n_phase = S_PRE2;
            end
            S_PRE2: begin
                n_phase = (i_byte == PREAMBLE_BYTE) ? S_SKIP : S_HUNT;
            end
            S_SKIP: begin
                if (i_byte != PREAMBLE_BYTE) begin
                    n_xor   = i_byte & HIGH_MASK;
                    n_crc   = crc8_feed(CRC_INIT, i_byte & HIGH_MASK);
                    n_id    = {i_byte, 8'h00};
                    n_phase = S_LOW;
                end
            end
            S_LOW: begin
                n_xor   = r_xor ^ i_byte;
                n_crc   = crc8_feed(r_crc, i_byte);
                n_id    = {r_id[15:8], i_byte};
                n_phase = S_CRC;
            end
            S_CRC: begin
                n_xor   = r_xor ^ i_byte;
                n_phase = (r_crc == i_byte) ? S_XOR : S_HUNT;
            end
            S_XOR: begin
                o_result.hit = (r_xor == i_byte);
                n_phase      = S_HUNT;
            end
            default: begin
                n_phase = S_HUNT;
            end
        endcase
        if (!i_step) o_result.hit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_HUNT;
            r_xor   <= 8'h00;
            r_crc   <= 8'h00;
            r_id    <= 16'h0000;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_crc   <= n_crc;
            r_id    <= n_id;
        end
    end

endmodule

// File: hdl/tag_frame_parser_crc8_top.sv
// ----------------------------------------------------------------------------
// tag_frame_parser_crc8_top
// Tag frame parser: input register, frame state machine, result register.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register; the ID of a good frame is
// taken into the result register when its XOR byte steps the parser.
// Throughput: one byte per cycle while the result slot is free or is being emptied.
// Reset: synchronous, active low; clears both valid flags and the parser
// back to the preamble hunt.
module tag_frame_parser_crc8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [15:0] tag_id
);
    import tfp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [15:0] r_out_id;
    logic        w_advance;
    t_tfp_result w_result;

    // The held byte moves through the parser when the result slot is free
    // or is being emptied in the same cycle.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    tfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance && w_result.hit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_advance && w_result.hit) begin
            r_out_id <= w_result.id;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;

    // A result is only raised by a parser step that found a frame.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && w_result.hit))
        else $error("result raised without a finished frame");

    // A held byte that cannot advance stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");

    // The parser never steps without a held byte.
    a_step_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> r_in_valid)
        else $error("parser stepped without a byte");

    // A stalled result is never overwritten by a new frame.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_advance)
        else $error("result overrun");

endmodule

// File: bench/tb_tag_frame_parser_crc8_top.sv
// ----------------------------------------------------------------------------
// tb_tag_frame_parser_crc8_top
// Self-checking bench for the tag frame parser with CRC-8 check.
// ----------------------------------------------------------------------------
// A short directed table walks the preamble, skip, CRC and XOR paths and
// the byte extremes. Random traffic follows: mostly well-formed frames with
// random IDs, some with a corrupted CRC or XOR byte, plus cut-off frames and
// noise. A bench-side parser predicts the tag IDs, except on directed rows that
// give their ID in the table. Both stream sides idle at random, except in one quiet stretch.
`timescale 1ns / 100ps

module tb_tag_frame_parser_crc8_top;

    import tfp_pkg::*;

    localparam int BYTES_TOTAL = 1400;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PRE2,
        PH_HIGH,
        PH_LOW,
        PH_CRC,
        PH_XOR
    } t_phase;

    typedef enum logic [2:0] {
        ROW_BYTE,
        ROW_CRC_OK,
        ROW_CRC_BAD,
        ROW_XOR_OK,
        ROW_XOR_BAD
    } t_row_kind;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ID
    } t_row_check;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;
        t_row_check check;
        logic [15:0] id;
    } t_dir_row;

    // CRC and XOR rows take their byte from the parser state at send time.
    localparam t_dir_row DIR_ROWS [0:25] = '{
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h00, CHK_MODEL, 16'h0000},  // second preamble missing
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},  // extra preamble, skipped
        '{ROW_BYTE,    8'hFF, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hFF, CHK_MODEL, 16'h0000},
        '{ROW_CRC_OK,  8'h00, CHK_MODEL, 16'h0000},
        '{ROW_XOR_OK,  8'h00, CHK_ID,    16'hFFFF},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h00, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h00, CHK_MODEL, 16'h0000},
        '{ROW_CRC_BAD, 8'h00, CHK_NONE,  16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h20, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},  // low byte may be 0xAA
        '{ROW_CRC_OK,  8'h00, CHK_MODEL, 16'h0000},
        '{ROW_XOR_BAD, 8'h00, CHK_NONE,  16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'hAA, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h80, CHK_MODEL, 16'h0000},
        '{ROW_BYTE,    8'h01, CHK_MODEL, 16'h0000},
        '{ROW_CRC_OK,  8'h00, CHK_MODEL, 16'h0000},
        '{ROW_XOR_OK,  8'h00, CHK_ID,    16'h8001}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        m_tready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;

    // Bench-side copy of the parser state.
    t_phase      phase;
    logic [4:0]  hi_masked;
    logic [7:0]  lo_byte;
    logic [7:0]  xor_acc;
    logic [15:0] id_acc;

    logic [15:0] ids_due [$];
    int          mismatches;
    int          ids_checked;
    int          bytes_sent;
    logic        no_idle;

    tag_frame_parser_crc8_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            fb = r[7];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic tag_parse_step(input logic [7:0] b, output logic hit,
                                  output logic [15:0] id);
        logic [7:0] crc_calc;
        hit = 1'b0;
        id  = '0;
        case (phase)
            PH_HUNT: begin
                if (b == PREAMBLE_BYTE) phase = PH_PRE2;
            end
            PH_PRE2: begin
                phase = (b == PREAMBLE_BYTE) ? PH_HIGH : PH_HUNT;
            end
            PH_HIGH: begin
                if (b != PREAMBLE_BYTE) begin
                    hi_masked = b[4:0];
                    xor_acc   = {3'b000, b[4:0]};
                    id_acc    = {b, 8'h00};
                    phase     = PH_LOW;
                end
            end
            PH_LOW: begin
                lo_byte     = b;
                xor_acc     = xor_acc ^ b;
                id_acc[7:0] = b;
                phase       = PH_CRC;
            end
            PH_CRC: begin
                xor_acc  = xor_acc ^ b;
                crc_calc = crc8_byte(crc8_byte(CRC_INIT, {3'b000, hi_masked}), lo_byte);
                phase    = (crc_calc == b) ? PH_XOR : PH_HUNT;
            end
            PH_XOR: begin
                if (xor_acc == b) begin
                    hit = 1'b1;
                    id  = id_acc;
                end
                phase = PH_HUNT;
            end
            default: begin
                phase = PH_HUNT;
            end
        endcase
    endtask

    // Sends one beat, possibly after a random gap, and records what it should cause.
    task automatic push_byte(input logic [7:0] b, input t_row_check check,
                             input logic [15:0] typed_id);
        logic        hit;
        logic [15:0] id;
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        tag_parse_step(b, hit, id);
        if (check == CHK_MODEL && hit) begin
            ids_due.push_back(id);
        end else if (check == CHK_ID) begin
            ids_due.push_back(typed_id);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (ids_due.size() != 0);
    endtask

    // A frame with a random ID; cut > 0 sends only its first cut bytes.
    task automatic send_frame(input int cut);
        logic [7:0] fr [$];
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] crc;
        logic [7:0] chk;
        int         extra;
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        case ($urandom_range(0, 7))
            0:       hi = 8'h00;
            1:       hi = 8'hFF;
            default: begin
                do hi = 8'($urandom); while (hi == PREAMBLE_BYTE);
            end
        endcase
        lo  = 8'($urandom);
        crc = crc8_byte(crc8_byte(CRC_INIT, hi & HIGH_MASK), lo);
        chk = (hi & HIGH_MASK) ^ lo ^ crc;
        if ($urandom_range(0, 9) == 0) crc = crc ^ (8'h01 << $urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) chk = chk ^ (8'h01 << $urandom_range(0, 7));
        fr = '{PREAMBLE_BYTE, PREAMBLE_BYTE};
        repeat (extra) fr.push_back(PREAMBLE_BYTE);
        fr.push_back(hi);
        fr.push_back(lo);
        fr.push_back(crc);
        fr.push_back(chk);
        if (cut > 0 && cut < fr.size()) fr = fr[0:cut-1];
        foreach (fr[i]) push_byte(fr[i], CHK_MODEL, 16'h0000);
    endtask

    task automatic check_id(input logic [15:0] got);
        logic [15:0] want;
        if (ids_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected tag ID 0x%04h", got);
        end else begin
            want = ids_due.pop_front();
            ids_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tag ID mismatch: expected 0x%04h, got 0x%04h", want, got);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) check_id(o_m_axis_tdata);
        m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [7:0] b;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        m_tready    = 1'b0;
        no_idle     = 1'b0;
        mismatches  = 0;
        ids_checked = 0;
        bytes_sent  = 0;
        phase       = PH_HUNT;
        hi_masked   = '0;
        lo_byte     = '0;
        xor_acc     = '0;
        id_acc      = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[r]) begin
            case (DIR_ROWS[r].kind)
                ROW_CRC_OK:  b = crc8_byte(crc8_byte(CRC_INIT, {3'b000, hi_masked}), lo_byte);
                ROW_CRC_BAD: b = crc8_byte(crc8_byte(CRC_INIT, {3'b000, hi_masked}), lo_byte)
                                 ^ 8'h01;
                // The XOR byte must match the accumulator as it stands after the CRC byte.
                ROW_XOR_OK:  b = xor_acc;
                ROW_XOR_BAD: b = xor_acc ^ 8'h80;
                default:     b = DIR_ROWS[r].data;
            endcase
            push_byte(b, DIR_ROWS[r].check, DIR_ROWS[r].id);
        end
        hold_until_drained();

        while (bytes_sent < BYTES_TOTAL) begin
            no_idle = (bytes_sent >= 500 && bytes_sent < 800);
            if (bytes_sent >= 900 && bytes_sent < 910) hold_until_drained();
            case ($urandom_range(0, 99)) inside
                [0:69]:  send_frame(0);
                [70:81]: send_frame($urandom_range(1, 5));
                [82:87]: begin
                    push_byte(PREAMBLE_BYTE, CHK_MODEL, 16'h0000);
                    push_byte(8'($urandom), CHK_MODEL, 16'h0000);
                end
                default: begin
                    repeat ($urandom_range(1, 5)) begin
                        b = ($urandom_range(0, 3) == 0) ? PREAMBLE_BYTE : 8'($urandom);
                        push_byte(b, CHK_MODEL, 16'h0000);
                    end
                end
            endcase
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        for (int w = 0; w < 5000 && ids_due.size() != 0; w++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (ids_due.size() != 0) begin
            mismatches += ids_due.size();
            $display("%0d tag IDs never arrived", ids_due.size());
        end

        $display("Sent %0d bytes: directed table, random good and corrupted frames,", bytes_sent);
        $display("cut-off frames and noise; %0d tag IDs compared.", ids_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
